// ----- rtl/core/g5x7r_pkg.sv -----
// Shared types, constants and the 5x7 font table of the glyph rasterizer.
package g5x7r_pkg;

  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_COLS = 5;

  localparam int SURF_W_BITS = 13;
  localparam int SURF_H_BITS = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = SURF_W_BITS;

  localparam int MAX_SURFACE_HEIGHT_DEF = 64;

  localparam logic [SURF_W_BITS-1:0] SURF_W_RESET = 13'd640;
  localparam logic [SURF_H_BITS-1:0] SURF_H_RESET = 7'd64;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [7:0]         char_code;
    logic signed [11:0] origin_x;
    logic signed [11:0] origin_y;
  } req_t;

  typedef struct packed {
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [4:0]         row0_mask;
    logic [4:0]         row1_mask;
    logic [4:0]         row2_mask;
    logic [4:0]         row3_mask;
    logic [4:0]         row4_mask;
    logic [4:0]         row5_mask;
    logic [4:0]         row6_mask;
  } rsp_t;

  // Row 0 is the leftmost element, so literals read top row first.
  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_t;

  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    logic [7:0] key;
    glyph_t     g;
    key = code;
    // fold lower case onto upper case
    if (code >= 8'h61 && code <= 8'h7A) begin
      key = code - 8'h20;
    end
    case (key)
      8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // A
      8'h42: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      8'h43: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      8'h44: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      8'h46: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h47: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h13, 5'h11, 5'h0E};
      8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      8'h49: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      8'h4A: g = {5'h1F, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
      8'h4B: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      8'h4E: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h51: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
      8'h58: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      8'h59: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h5A: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}; // Z
      8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}; // 0
      8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      8'h33: g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      8'h35: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      8'h36: g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}; // 9
      8'h5B: g = {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E}; // [
      8'h5D: g = {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E}; // ]
      8'h3A: g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}; // :
      8'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C}; // .
      8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}; // -
      8'h20: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}; // space
      default: g = {5'h1E, 5'h11, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04}; // ?
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/core/glyph_5x7_rasterizer_with_clip.sv -----
// On-screen-display 5x7 character generator with surface clipping.
//
// Request channel: drive req (character code and signed glyph origin) and
// pulse start. A request is taken on every rising edge where start is high
// and busy is low; busy is never raised, so one request per cycle is taken.
// Result channel: done is high for one cycle with result holding the origin
// echo and the seven clipped row masks. The receiver cannot stall; a result
// is valid only in its done cycle.
// Pipeline: one input register and one result register, with glyph lookup and
// clip logic in between.
// Throughput: one request per cycle.
// Configuration: write surface_width (index 0) or surface_height (index 1)
// through cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write only
// while no request is in flight. Other indexes are ignored.
// Reset (rst, synchronous): drops any request in flight and sets the surface
// to 640 x 64.
module glyph_5x7_rasterizer_with_clip #(
  parameter int MAX_SURFACE_HEIGHT = g5x7r_pkg::MAX_SURFACE_HEIGHT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  g5x7r_pkg::req_t                       req,
  output logic                                  done,
  output g5x7r_pkg::rsp_t                       result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [g5x7r_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [g5x7r_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import g5x7r_pkg::*;

  logic                    in_valid;
  req_t                    in_req;
  rsp_t                    rsp_next;
  logic [SURF_W_BITS-1:0]  surface_width;
  logic [SURF_H_BITS-1:0]  surface_height;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      done           <= 1'b0;
      surface_width  <= SURF_W_RESET;
      surface_height <= SURF_H_RESET;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SURFACE_WIDTH:  surface_width  <= cfg_data;
          CFG_SURFACE_HEIGHT: surface_height <= cfg_data[SURF_H_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_req <= req;
    end
    if (in_valid) begin
      result <= rsp_next;
    end
  end

  g5x7r_clip #(
    .MAX_SURFACE_HEIGHT(MAX_SURFACE_HEIGHT)
  ) u_clip (
    .req           (in_req),
    .surface_width (surface_width),
    .surface_height(surface_height),
    .rsp           (rsp_next)
  );

endmodule

// ----- rtl/core/g5x7r_clip.sv -----
// Glyph lookup and surface clipping for one registered request.
module g5x7r_clip #(
  parameter int MAX_SURFACE_HEIGHT = g5x7r_pkg::MAX_SURFACE_HEIGHT_DEF
) (
  input  g5x7r_pkg::req_t                         req,
  input  logic [g5x7r_pkg::SURF_W_BITS-1:0]       surface_width,
  input  logic [g5x7r_pkg::SURF_H_BITS-1:0]       surface_height,
  output g5x7r_pkg::rsp_t                         rsp
);
  import g5x7r_pkg::*;

  localparam int HW = $clog2(MAX_SURFACE_HEIGHT + 1);
  localparam int CW = (HW > 12) ? HW : 12;

  glyph_t                     glyph;
  logic [CW-1:0]              eff_h;
  logic [GLYPH_COLS-1:0]      col_mask;
  logic [GLYPH_ROWS-1:0]      row_ok;
  logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] masks;

  assign glyph = glyph_lookup(req.char_code);

  // cap height at the largest supported surface
  always_comb begin
    if (CW'(surface_height) > CW'(MAX_SURFACE_HEIGHT)) begin
      eff_h = CW'(MAX_SURFACE_HEIGHT);
    end else begin
      eff_h = CW'(surface_height);
    end
  end

  always_comb begin
    logic [12:0] px;
    col_mask = '0;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      px = {req.origin_x[11], req.origin_x} + 13'(c);
      col_mask[GLYPH_COLS-1-c] = !px[12] && ({1'b0, px[11:0]} < surface_width);
    end
  end

  always_comb begin
    logic [12:0] py;
    row_ok = '0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      py = {req.origin_y[11], req.origin_y} + 13'(r);
      row_ok[r] = !py[12] && (CW'(py[11:0]) < eff_h);
    end
  end

  always_comb begin
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      masks[r] = glyph[r] & col_mask & {GLYPH_COLS{row_ok[r]}};
    end
  end

  always_comb begin
    rsp.pos_x     = req.origin_x;
    rsp.pos_y     = req.origin_y;
    rsp.row0_mask = masks[0];
    rsp.row1_mask = masks[1];
    rsp.row2_mask = masks[2];
    rsp.row3_mask = masks[3];
    rsp.row4_mask = masks[4];
    rsp.row5_mask = masks[5];
    rsp.row6_mask = masks[6];
  end

endmodule

// ----- rtl/core/g5x7r_checker.sv -----
// Port-level assertions for the glyph rasterizer, bound to the top level.
module g5x7r_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input g5x7r_pkg::req_t                     req,
  input logic                                done,
  input g5x7r_pkg::rsp_t                     result,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [g5x7r_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input logic [g5x7r_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // every accepted request yields a result through the input and result registers
  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted request produced no result");

  // no result without an accepted request ahead of it
  a_done_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a request");

  a_origin_echo: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.pos_x == $past(req.origin_x, 2)) &&
             (result.pos_y == $past(req.origin_y, 2)))
    else $error("origin echo mismatch");

  // a glyph above the surface top loses its first row
  a_top_clip: assert property (@(posedge clk) disable iff (rst)
    (done && $past(req.origin_y[11], 2)) |-> (result.row0_mask == 5'd0))
    else $error("row above surface not clipped");

  // a glyph left of the surface loses its leftmost column
  a_left_clip: assert property (@(posedge clk) disable iff (rst)
    (done && $past(req.origin_x[11], 2)) |->
      !(result.row0_mask[4] || result.row1_mask[4] || result.row2_mask[4] ||
        result.row3_mask[4] || result.row4_mask[4] || result.row5_mask[4] ||
        result.row6_mask[4]))
    else $error("column left of surface not clipped");

endmodule

bind glyph_5x7_rasterizer_with_clip g5x7r_checker u_checker (.*);

// ----- bench/tb_top.sv -----
// Self-checking bench for the clipped 5x7 glyph rasterizer: font, case fold, clipping, config.
`timescale 1ns / 1ps

module tb_top;
  import g5x7r_pkg::*;

  localparam int MAX_H       = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 4;

  // indexes the block must ignore
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  req_t                   req;
  logic                   done;
  rsp_t                   result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // shadow of the surface registers
  int   surf_w;
  int   surf_h;
  rsp_t glyph_q[$];
  int   err_count;
  int   cycle_count;
  rsp_t want_rsp;
  string font_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789[]:.- abcdefghijklmnopqrstuvwxyz";

  glyph_5x7_rasterizer_with_clip #(
    .MAX_SURFACE_HEIGHT(MAX_H)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Rows top to bottom, row 0 in the top five bits.
  function automatic logic [34:0] font_rows(logic [7:0] code);
    logic [7:0] ch;
    ch = code;
    if (code >= "a" && code <= "z") ch = code - 8'h20;
    case (ch)
      "A": return {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "B": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      "C": return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      "D": return {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      "E": return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      "F": return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      "G": return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h13, 5'h11, 5'h0E};
      "H": return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "I": return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      "J": return {5'h1F, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
      "K": return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      "L": return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "M": return {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      "N": return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      "O": return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "P": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      "Q": return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      "R": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      "S": return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "T": return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "U": return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "V": return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      "W": return {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
      "X": return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      "Y": return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      "Z": return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      "0": return {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      "1": return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "2": return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      "3": return {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "4": return {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      "5": return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      "6": return {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      "7": return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      "8": return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      "9": return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
      "[": return {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
      "]": return {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E};
      ":": return {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      ".": return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
      "-": return {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      " ": return 35'd0;
      default: return {5'h1E, 5'h11, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
    endcase
  endfunction

  function automatic rsp_t predict_glyph(req_t r);
    logic [34:0] rows;
    logic [4:0]  cols;
    logic [4:0]  m[0:6];
    int          ox, oy, h, k;
    rsp_t        e;
    rows = font_rows(r.char_code);
    ox = $signed(r.origin_x);
    oy = $signed(r.origin_y);
    h = (surf_h > MAX_H) ? MAX_H : surf_h;
    cols = '0;
    for (k = 0; k < 5; k++) begin
      if (ox + k >= 0 && ox + k < surf_w) cols[4-k] = 1'b1;
    end
    for (k = 0; k < 7; k++) begin
      if (oy + k >= 0 && oy + k < h) m[k] = rows[34-5*k -: 5] & cols;
      else m[k] = '0;
    end
    e.pos_x     = r.origin_x;
    e.pos_y     = r.origin_y;
    e.row0_mask = m[0];
    e.row1_mask = m[1];
    e.row2_mask = m[2];
    e.row3_mask = m[3];
    e.row4_mask = m[4];
    e.row5_mask = m[5];
    e.row6_mask = m[6];
    return e;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // Compare each strobed result against the oldest pending glyph.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (glyph_q.size() == 0) begin
        $error("result with no pending request: pos_x %0d pos_y %0d",
               $signed(result.pos_x), $signed(result.pos_y));
        err_count++;
      end else begin
        want_rsp = glyph_q.pop_front();
        check_field("pos_x", int'($signed(want_rsp.pos_x)), int'($signed(result.pos_x)));
        check_field("pos_y", int'($signed(want_rsp.pos_y)), int'($signed(result.pos_y)));
        check_field("row0_mask", want_rsp.row0_mask, result.row0_mask);
        check_field("row1_mask", want_rsp.row1_mask, result.row1_mask);
        check_field("row2_mask", want_rsp.row2_mask, result.row2_mask);
        check_field("row3_mask", want_rsp.row3_mask, result.row3_mask);
        check_field("row4_mask", want_rsp.row4_mask, result.row4_mask);
        check_field("row5_mask", want_rsp.row5_mask, result.row5_mask);
        check_field("row6_mask", want_rsp.row6_mask, result.row6_mask);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Leaves start high so back-to-back requests stream without a bubble.
  task automatic send_glyph(logic [7:0] code, int x, int y);
    req_t r;
    r.char_code = code;
    r.origin_x  = x[11:0];
    r.origin_y  = y[11:0];
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    glyph_q.push_back(predict_glyph(r));
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Hold off until every pending result is back and the pipe is empty.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (glyph_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_surface(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SURFACE_WIDTH:  surf_w = int'(data);
      CFG_SURFACE_HEIGHT: surf_h = int'(data[SURF_H_BITS-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int clamp12(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  // Bias origins toward the clip edges; the rest spans the full range.
  function automatic int pick_origin(int limit);
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 4095)) - 2048;
      1: return int'($urandom_range(0, 10)) - 6;
      default: return clamp12(limit - 7 + int'($urandom_range(0, 9)));
    endcase
  endfunction

  task automatic send_random_glyph();
    logic [7:0] code;
    int         sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) code = font_chars[$urandom_range(0, font_chars.len() - 1)];
    else if (sel < 8) code = 8'($urandom_range(0, 255));
    else code = 8'($urandom_range(8'h20, 8'h7F));
    send_glyph(code, pick_origin(surf_w), pick_origin((surf_h > MAX_H) ? MAX_H : surf_h));
  endtask

  task automatic run_glyph_stream(int n, bit gaps);
    int sent, burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        send_random_glyph();
        sent++;
      end
      if (gaps && $urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 5));
    end
  endtask

  task automatic test_font_and_fold();
    send_glyph("A", 0, 0);
    send_glyph("z", 100, 10);
    send_glyph("a", 20, 20);
    send_glyph("0", 30, 5);
    send_glyph("9", 40, 5);
    send_glyph("[", 50, 5);
    send_glyph("]", 60, 5);
    send_glyph(":", 70, 5);
    send_glyph(".", 80, 5);
    send_glyph("-", 90, 5);
    send_glyph(" ", 95, 5);
    // just outside the fold range and the high half give the fallback
    send_glyph(8'h60, 110, 5);
    send_glyph(8'h7B, 120, 5);
    send_glyph(8'h80, 130, 5);
    send_glyph(8'hFF, 140, 5);
    send_glyph(8'h00, 150, 5);
  endtask

  task automatic test_clip_edges();
    send_glyph("H", -4, 0);
    send_glyph("H", 636, 0);
    send_glyph("H", 0, -6);
    send_glyph("H", 0, 60);
    send_glyph("M", -2048, -2048);
    send_glyph("W", 2047, 2047);
    wait_idle();
  endtask

  task automatic test_surface_extremes();
    write_surface(CFG_SURFACE_WIDTH, 13'd1);
    write_surface(CFG_SURFACE_HEIGHT, 13'd1);
    send_glyph("B", 0, 0);
    send_glyph("B", -1, -1);
    wait_idle();
    // zero width and height: nothing survives
    write_surface(CFG_SURFACE_WIDTH, 13'd0);
    write_surface(CFG_SURFACE_HEIGHT, 13'd0);
    send_glyph("8", 0, 0);
    wait_idle();
    // height above the cap, upper data bits must be dropped for height
    write_surface(CFG_SURFACE_WIDTH, 13'h1FFF);
    write_surface(CFG_SURFACE_HEIGHT, 13'h1F7F);
    send_glyph("E", 2047, 58);
    send_glyph("E", -2, 60);
    wait_idle();
    write_surface(CFG_SPARE_A, 13'd3);
    write_surface(CFG_SPARE_B, 13'd2);
    send_glyph("R", 2045, 57);
    wait_idle();
  endtask

  task automatic test_random_phases();
    int p, w, h;
    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin w = 1;    h = 1;   end
        1: begin w = 4096; h = 64;  end
        2: begin w = 8191; h = 127; end
        3: begin w = $urandom_range(1, 64);   h = $urandom_range(1, 64); end
        4: begin w = $urandom_range(1, 4096); h = $urandom_range(7, 70); end
        5: begin w = 0;    h = $urandom_range(1, 64); end
        6: begin w = $urandom_range(1, 4096); h = 0; end
        default: begin w = $urandom_range(1, 4096); h = 65; end
      endcase
      write_surface(CFG_SURFACE_WIDTH, w[CFG_DATA_W-1:0]);
      write_surface(CFG_SURFACE_HEIGHT, h[CFG_DATA_W-1:0]);
      if (p == 3) begin
        // pause mid-phase until everything in flight has returned
        run_glyph_stream(80, 1'b1);
        wait_idle();
        run_glyph_stream(80, 1'b1);
      end else begin
        run_glyph_stream(160, p % 3 != 1);
      end
      wait_idle();
    end
  endtask

  initial begin
    err_count   = 0;
    cycle_count = 0;
    surf_w      = int'(SURF_W_RESET);
    surf_h      = int'(SURF_H_RESET);
    rst         = 1'b1;
    start       = 1'b0;
    req         = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_SURFACE_WIDTH;
    cfg_data    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_font_and_fold();
    test_clip_edges();
    test_surface_extremes();
    test_random_phases();

    wait_idle();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/g5x7r_pkg.sv
rtl/core/g5x7r_clip.sv
rtl/core/glyph_5x7_rasterizer_with_clip.sv
rtl/core/g5x7r_checker.sv
bench/tb_top.sv
